/* hdl/status_led_effect_sequencer_defines.svh */
// Assertion macros for the RTL of the status LED sequencer.
`ifndef STATUS_LED_EFFECT_SEQUENCER_DEFINES_SVH
`define STATUS_LED_EFFECT_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SLES_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLES_ASSERT(lbl, prop, msg) \
  `SLES_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define SLES_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SLES_ASSERT(lbl, prop, msg)
`endif

`endif

/* hdl/sles_pkg.sv */
package sles_pkg;

  typedef enum logic [3:0] {
    MODE_OFF    = 4'd0,
    MODE_IDLE   = 4'd1,
    MODE_SCAN   = 4'd2,
    MODE_ATTACK = 4'd3,
    MODE_PING   = 4'd4,
    MODE_BLIP   = 4'd5,
    MODE_BOOT   = 4'd6,
    MODE_DONE   = 4'd7,
    MODE_ERROR  = 4'd8
  } mode_e;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int unsigned IDLE_PERIOD_MS = 1500;
  localparam int unsigned SCAN_PERIOD_MS = 600;
  localparam int unsigned IDLE_STEPS     = 150;
  localparam int unsigned SCAN_STEPS     = 60;
  localparam int unsigned ATTACK_PERIOD  = 160;
  localparam int unsigned ATTACK_STEPS   = 2;
  localparam int unsigned PHASE_WRAP     = 12000;
  localparam int unsigned LONG_ADV_MS    = 40;
  localparam int unsigned SHORT_ADV_MS   = 30;
  localparam int unsigned BOOT_RAMP      = 21;

  localparam int unsigned PHASE_W = 14;
  localparam int unsigned TIMER_W = 8;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned IDLE_IDX_W = $clog2(IDLE_STEPS);
  localparam int unsigned SCAN_IDX_W = $clog2(SCAN_STEPS);
  localparam int unsigned ATK_IDX_W  = $clog2(ATTACK_STEPS);

  typedef struct packed {
    logic       operation;
    logic [3:0] new_mode;
  } sles_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] active_mode;
  } sles_out_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [TIMER_W-1:0] dur;
    logic [STEP_W-1:0]  count;
  } seg_t;

  localparam logic [7:0] IDLE_LEVELS [IDLE_STEPS] = '{
    8'd23, 8'd23, 8'd24, 8'd24, 8'd25, 8'd26, 8'd26, 8'd27, 8'd27, 8'd28,
    8'd29, 8'd29, 8'd30, 8'd30, 8'd31, 8'd31, 8'd32, 8'd32, 8'd33, 8'd33,
    8'd34, 8'd34, 8'd34, 8'd35, 8'd35, 8'd35, 8'd36, 8'd36, 8'd36, 8'd37,
    8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37,
    8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd37, 8'd36, 8'd36, 8'd36,
    8'd35, 8'd35, 8'd35, 8'd34, 8'd34, 8'd34, 8'd33, 8'd33, 8'd32, 8'd32,
    8'd31, 8'd31, 8'd30, 8'd30, 8'd29, 8'd29, 8'd28, 8'd27, 8'd27, 8'd26,
    8'd26, 8'd25, 8'd24, 8'd24, 8'd23, 8'd22, 8'd22, 8'd21, 8'd21, 8'd20,
    8'd19, 8'd19, 8'd18, 8'd18, 8'd17, 8'd16, 8'd16, 8'd15, 8'd15, 8'd14,
    8'd14, 8'd13, 8'd13, 8'd12, 8'd12, 8'd11, 8'd11, 8'd11, 8'd10, 8'd10,
    8'd10, 8'd9,  8'd9,  8'd9,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,
    8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,
    8'd8,  8'd8,  8'd9,  8'd9,  8'd9,  8'd10, 8'd10, 8'd10, 8'd11, 8'd11,
    8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16,
    8'd16, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd21, 8'd21, 8'd22
  };

  localparam logic [7:0] SCAN_LEVELS [SCAN_STEPS] = '{
    8'd60,  8'd64, 8'd68, 8'd72, 8'd76, 8'd80, 8'd83, 8'd86, 8'd89, 8'd92,
    8'd94,  8'd96, 8'd98, 8'd99, 8'd99, 8'd100, 8'd99, 8'd99, 8'd98, 8'd96,
    8'd94,  8'd92, 8'd89, 8'd86, 8'd83, 8'd79, 8'd76, 8'd72, 8'd68, 8'd64,
    8'd59,  8'd55, 8'd51, 8'd47, 8'd43, 8'd39, 8'd36, 8'd33, 8'd30, 8'd27,
    8'd25,  8'd23, 8'd21, 8'd20, 8'd20, 8'd20, 8'd20, 8'd20, 8'd21, 8'd23,
    8'd25,  8'd27, 8'd30, 8'd33, 8'd36, 8'd40, 8'd43, 8'd47, 8'd51, 8'd55
  };

  // Blue level of the boot swell, v * 60 / 255 for v = 8 * k.
  localparam logic [7:0] BOOT_BLUE [BOOT_RAMP] = '{
    8'd0,  8'd1,  8'd3,  8'd5,  8'd7,  8'd9,  8'd11, 8'd13, 8'd15, 8'd16,
    8'd18, 8'd20, 8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd33, 8'd35,
    8'd37
  };

endpackage

/* hdl/status_led_effect_sequencer.sv */
// Status LED effect sequencer.
// The input channel carries one beat per millisecond tick or per mode write.
// Every accepted beat yields exactly one result beat with the colour shown
// and the mode of the current frame. A written mode waits until the next
// frame boundary. One-shot modes fall back to idle, or to scan after the
// blip, when their last segment ends.
// Each result beat is registered in the output stage, and one beat is
// accepted per cycle while in_ready_o is high. The whole update runs in one
// pass from the state registers to the result register; table indexes come
// from small phase trackers that step along with the phase time.
// Results sit in a two-entry output stage, so one more input beat is taken
// while a result waits; with both entries full, in_ready_o goes low until
// the receiver takes a beat.
// After reset the mode is off, the colour is black and the first tick starts
// a new frame.
`include "status_led_effect_sequencer_defines.svh"

module status_led_effect_sequencer #(
  parameter int unsigned IDLE_PERIOD_MS = sles_pkg::IDLE_PERIOD_MS,
  parameter int unsigned SCAN_PERIOD_MS = sles_pkg::SCAN_PERIOD_MS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sles_pkg::sles_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sles_pkg::sles_out_t out_data_o
);

  sles_pkg::mode_e current_q, current_d, pending_q, pending_d, mode_cur;
  logic [sles_pkg::PHASE_W-1:0] phase_q, phase_d, phase_sum;
  logic [sles_pkg::TIMER_W-1:0] timer_q, timer_d, timer_dec;
  logic [sles_pkg::STEP_W-1:0]  step_q, step_d, step_inc;
  logic [7:0] red_q, red_d, green_q, green_d, blue_q, blue_d;

  logic [sles_pkg::IDLE_IDX_W-1:0] idle_idx;
  logic [sles_pkg::SCAN_IDX_W-1:0] scan_idx;
  logic [sles_pkg::ATK_IDX_W-1:0]  atk_idx;
  sles_pkg::seg_t seg;

  logic in_fire, out_fire, is_tick, start, phased, adv, long_adv, wrap, seg_end;
  sles_pkg::sles_out_t result, out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign is_tick    = (in_data_i.operation == sles_pkg::OP_TICK);

  assign start    = (timer_q == '0);
  assign mode_cur = (start && step_q == '0) ? pending_q : current_q;
  assign phased   = (mode_cur == sles_pkg::MODE_IDLE) || (mode_cur == sles_pkg::MODE_SCAN)
                 || (mode_cur == sles_pkg::MODE_ATTACK);
  assign long_adv = (mode_cur != sles_pkg::MODE_SCAN);
  assign phase_sum = phase_q + (long_adv ? sles_pkg::PHASE_W'(sles_pkg::LONG_ADV_MS)
                                         : sles_pkg::PHASE_W'(sles_pkg::SHORT_ADV_MS));
  assign wrap = (phase_sum >= sles_pkg::PHASE_W'(sles_pkg::PHASE_WRAP));
  assign adv  = in_fire && is_tick && start && phased;

  sles_phase_track #(.PERIOD(IDLE_PERIOD_MS), .STEPS(sles_pkg::IDLE_STEPS)) u_idle_track (
    .clk_i, .rst_ni, .adv_i(adv), .long_i(long_adv), .wrap_i(wrap), .idx_o(idle_idx)
  );

  sles_phase_track #(.PERIOD(SCAN_PERIOD_MS), .STEPS(sles_pkg::SCAN_STEPS)) u_scan_track (
    .clk_i, .rst_ni, .adv_i(adv), .long_i(long_adv), .wrap_i(wrap), .idx_o(scan_idx)
  );

  sles_phase_track #(.PERIOD(sles_pkg::ATTACK_PERIOD), .STEPS(sles_pkg::ATTACK_STEPS))
    u_atk_track (
    .clk_i, .rst_ni, .adv_i(adv), .long_i(long_adv), .wrap_i(wrap), .idx_o(atk_idx)
  );

  sles_segment u_segment (
    .mode_i(mode_cur), .step_i(step_q), .idle_idx_i(idle_idx), .scan_idx_i(scan_idx),
    .atk_idx_i(atk_idx), .seg_o(seg)
  );

  assign timer_dec = (start ? seg.dur : timer_q) - 8'd1;
  assign seg_end   = (timer_dec == '0);
  assign step_inc  = step_q + 6'd1;

  always_comb begin
    current_d = current_q;
    pending_d = pending_q;
    phase_d   = phase_q;
    timer_d   = timer_q;
    step_d    = step_q;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    if (is_tick) begin
      current_d = mode_cur;
      timer_d   = timer_dec;
      if (start) begin
        red_d   = seg.red;
        green_d = seg.green;
        blue_d  = seg.blue;
        if (phased) begin
          phase_d = wrap ? sles_pkg::PHASE_W'(phase_sum - sles_pkg::PHASE_W'(sles_pkg::PHASE_WRAP))
                         : phase_sum;
        end
      end
      if (seg_end) begin
        if (step_inc >= seg.count) begin
          step_d = '0;
          if (mode_cur == sles_pkg::MODE_BLIP) begin
            pending_d = sles_pkg::MODE_SCAN;
          end else if (mode_cur >= sles_pkg::MODE_PING) begin
            pending_d = sles_pkg::MODE_IDLE;
          end
        end else begin
          step_d = step_inc;
        end
      end
    end else if (in_data_i.new_mode <= 4'(sles_pkg::MODE_ERROR)) begin
      pending_d = sles_pkg::mode_e'(in_data_i.new_mode);
    end
  end

  assign result = '{red: red_d, green: green_d, blue: blue_d, active_mode: current_d};

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_data_d  = result;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_data_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q    <= sles_pkg::MODE_OFF;
      pending_q    <= sles_pkg::MODE_OFF;
      phase_q      <= '0;
      timer_q      <= '0;
      step_q       <= '0;
      red_q        <= '0;
      green_q      <= '0;
      blue_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        current_q <= current_d;
        pending_q <= pending_d;
        phase_q   <= phase_d;
        timer_q   <= timer_d;
        step_q    <= step_d;
        red_q     <= red_d;
        green_q   <= green_d;
        blue_q    <= blue_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SLES_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid beat without output beat")
  `SLES_ASSERT(a_stall_fills_skid, (in_fire && out_valid_q && !out_ready_i) |=> skid_valid_q,
    "stalled result beat was dropped")
  `SLES_ASSERT(a_phase_range, phase_q < sles_pkg::PHASE_W'(sles_pkg::PHASE_WRAP),
    "phase time out of range")
  `SLES_ASSERT(a_step_oneshot, (step_q != '0) |-> ((current_q == sles_pkg::MODE_PING) ||
    (current_q == sles_pkg::MODE_BOOT) || (current_q == sles_pkg::MODE_DONE) ||
    (current_q == sles_pkg::MODE_ERROR)), "segment step set in a cyclic mode")

endmodule

/* hdl/sles_phase_track.sv */
module sles_phase_track #(
  parameter int unsigned PERIOD = sles_pkg::IDLE_PERIOD_MS,
  parameter int unsigned STEPS  = sles_pkg::IDLE_STEPS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     long_i,
  input  logic                     wrap_i,
  output logic [$clog2(STEPS)-1:0] idx_o
);

  localparam int unsigned FW  = $clog2(PERIOD);
  localparam int unsigned IW  = $clog2(STEPS);
  localparam int unsigned FSW = FW + 1;
  localparam int unsigned ISW = IW + 1;

  localparam int unsigned WRAP_REM = sles_pkg::PHASE_WRAP % PERIOD;
  localparam int unsigned E_LN = sles_pkg::LONG_ADV_MS % PERIOD;
  localparam int unsigned E_SN = sles_pkg::SHORT_ADV_MS % PERIOD;
  localparam int unsigned E_LW = (sles_pkg::LONG_ADV_MS + PERIOD - WRAP_REM) % PERIOD;
  localparam int unsigned E_SW = (sles_pkg::SHORT_ADV_MS + PERIOD - WRAP_REM) % PERIOD;
  localparam int unsigned Q_LN = (E_LN * STEPS) / PERIOD;
  localparam int unsigned R_LN = (E_LN * STEPS) % PERIOD;
  localparam int unsigned Q_SN = (E_SN * STEPS) / PERIOD;
  localparam int unsigned R_SN = (E_SN * STEPS) % PERIOD;
  localparam int unsigned Q_LW = (E_LW * STEPS) / PERIOD;
  localparam int unsigned R_LW = (E_LW * STEPS) % PERIOD;
  localparam int unsigned Q_SW = (E_SW * STEPS) / PERIOD;
  localparam int unsigned R_SW = (E_SW * STEPS) % PERIOD;

  // The phase remainder scaled by STEPS is held as idx * PERIOD + frac.
  logic [IW-1:0]  idx_q, idx_d;
  logic [FW-1:0]  frac_q, frac_d;
  logic [ISW-1:0] q_sel, idx_sum;
  logic [FSW-1:0] r_sel, frac_sum;
  logic           carry;

  always_comb begin
    if (wrap_i) begin
      q_sel = long_i ? ISW'(Q_LW) : ISW'(Q_SW);
      r_sel = long_i ? FSW'(R_LW) : FSW'(R_SW);
    end else begin
      q_sel = long_i ? ISW'(Q_LN) : ISW'(Q_SN);
      r_sel = long_i ? FSW'(R_LN) : FSW'(R_SN);
    end
    frac_sum = {1'b0, frac_q} + r_sel;
    carry    = (frac_sum >= FSW'(PERIOD));
    frac_d   = carry ? FW'(frac_sum - FSW'(PERIOD)) : frac_sum[FW-1:0];
    idx_sum  = {1'b0, idx_q} + q_sel + ISW'(carry);
    idx_d    = (idx_sum >= ISW'(STEPS)) ? IW'(idx_sum - ISW'(STEPS)) : idx_sum[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      frac_q <= '0;
    end else if (adv_i) begin
      idx_q  <= idx_d;
      frac_q <= frac_d;
    end
  end

  assign idx_o = idx_q;

endmodule

/* hdl/sles_segment.sv */
module sles_segment (
  input  sles_pkg::mode_e                   mode_i,
  input  logic [sles_pkg::STEP_W-1:0]       step_i,
  input  logic [sles_pkg::IDLE_IDX_W-1:0]   idle_idx_i,
  input  logic [sles_pkg::SCAN_IDX_W-1:0]   scan_idx_i,
  input  logic [sles_pkg::ATK_IDX_W-1:0]    atk_idx_i,
  output sles_pkg::seg_t                    seg_o
);

  logic [7:0] idle_lvl, scan_lvl;
  logic [4:0] boot_k;

  assign idle_lvl = sles_pkg::IDLE_LEVELS[idle_idx_i];
  assign scan_lvl = sles_pkg::SCAN_LEVELS[scan_idx_i];
  assign boot_k   = (step_i < sles_pkg::STEP_W'(sles_pkg::BOOT_RAMP)) ? step_i[4:0]
                  : 5'(6'd41 - step_i);

  always_comb begin
    seg_o = '{red: 8'd0, green: 8'd0, blue: 8'd0, dur: 8'd80, count: 6'd1};
    unique case (mode_i)
      sles_pkg::MODE_IDLE: begin
        seg_o.red  = idle_lvl;
        seg_o.blue = idle_lvl;
        seg_o.dur  = 8'd40;
      end
      sles_pkg::MODE_SCAN: begin
        seg_o.green = scan_lvl;
        seg_o.blue  = scan_lvl;
        seg_o.dur   = 8'd30;
      end
      sles_pkg::MODE_ATTACK: begin
        seg_o.red   = atk_idx_i[0] ? 8'd120 : 8'd0;
        seg_o.green = atk_idx_i[0] ? 8'd0 : 8'd120;
        seg_o.blue  = 8'd120;
        seg_o.dur   = 8'd40;
      end
      sles_pkg::MODE_PING: begin
        seg_o.count = 6'd2;
        if (step_i == '0) begin
          seg_o.green = 8'd200;
          seg_o.blue  = 8'd200;
          seg_o.dur   = 8'd200;
        end
      end
      sles_pkg::MODE_BLIP: begin
        seg_o.red   = 8'd120;
        seg_o.green = 8'd120;
        seg_o.blue  = 8'd120;
        seg_o.dur   = 8'd35;
      end
      sles_pkg::MODE_BOOT: begin
        seg_o.count = 6'd46;
        if (step_i < 6'd42) begin
          seg_o.green = {boot_k, 3'b000};
          seg_o.blue  = sles_pkg::BOOT_BLUE[boot_k];
          seg_o.dur   = 8'd8;
        end else if (!step_i[0]) begin
          seg_o.green = 8'd180;
          seg_o.blue  = 8'd60;
          seg_o.dur   = 8'd90;
        end else begin
          seg_o.dur   = 8'd110;
        end
      end
      sles_pkg::MODE_DONE: begin
        seg_o.count = 6'd4;
        if (!step_i[0]) begin
          seg_o.green = 8'd200;
          seg_o.blue  = 8'd40;
          seg_o.dur   = 8'd110;
        end else begin
          seg_o.dur   = 8'd90;
        end
      end
      sles_pkg::MODE_ERROR: begin
        seg_o.count = 6'd6;
        if (!step_i[0]) begin
          seg_o.red = 8'd200;
          seg_o.dur = 8'd110;
        end else begin
          seg_o.dur = 8'd90;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
